### design/region_map_protection_checker_top_macros.svh
// Assertion macros used by the region map protection checker's port-level checker.
`ifndef REGION_MAP_PROTECTION_CHECKER_TOP_MACROS_SVH
`define REGION_MAP_PROTECTION_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RMPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("region map checker: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RMPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("region map checker: assertion failed");

`endif

### design/rmpc_pkg.sv
// Types and constants shared by the region map protection checker modules.
package rmpc_pkg;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 35;
    localparam int PERM_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int OFFSET_W   = 34;

    localparam logic [CMD_W-1:0] CMD_MAP     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNMAP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PROTECT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd4;

    localparam int PERM_READ_BIT  = 0;
    localparam int PERM_WRITE_BIT = 1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [PERM_W-1:0] permissions;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [OFFSET_W-1:0]   region_offset;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } ctl_cmd_t;

endpackage

### design/rmpc_ctrl.sv
// Sequencer: steps each transaction through capture, slot compare and resolve.
module rmpc_ctrl
    import rmpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ctl_cmd_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        accept;
    logic        out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next  = state_reg;
        ctl.load    = 1'b0;
        ctl.compare = 1'b0;
        ctl.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.compare = 1'b1;
                state_next  = S_RES;
            end
            S_RES:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### design/rmpc_datapath.sv
// Region table, per-slot comparators and result formation.
module rmpc_datapath
    import rmpc_pkg::*;
#(
    parameter int REGION_SLOTS = 16,
    parameter int ADDR_BITS    = 34
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  ctl_cmd_t ctl,
    input  req_t     req_data,
    output rsp_t     rsp_data
);

    localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int AX_W   = ADDR_BITS + 1;
    localparam int SUM_W  = ((AX_W > LEN_W) ? AX_W : LEN_W) + 1;
    localparam logic [SUM_W-1:0] SPACE_SIZE = SUM_W'(1) << ADDR_BITS;

    // captured transaction
    req_t req_reg;

    // region table
    logic [REGION_SLOTS-1:0] valid_reg;
    logic [REGION_SLOTS-1:0] valid_next;
    logic [ADDR_BITS-1:0]    base_reg [REGION_SLOTS];
    logic [LEN_W-1:0]        len_reg  [REGION_SLOTS];
    logic [PERM_W-1:0]       perm_reg [REGION_SLOTS];

    // compare stage results
    logic                    bad_reg;
    logic                    bad_next;
    logic [REGION_SLOTS-1:0] overlap_reg;
    logic [REGION_SLOTS-1:0] overlap_next;
    logic [REGION_SLOTS-1:0] exact_reg;
    logic [REGION_SLOTS-1:0] exact_next;
    logic [REGION_SLOTS-1:0] hold_lo_reg;
    logic [REGION_SLOTS-1:0] hold_lo_next;
    logic [REGION_SLOTS-1:0] hold_eq_reg;
    logic [REGION_SLOTS-1:0] hold_eq_next;

    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic              addr_small;
    logic [AX_W-1:0]   addr_x;
    logic [SUM_W-1:0]  addr_s;
    logic [SUM_W-1:0]  end_s;
    logic              need_write;

    logic [REGION_SLOTS-1:0] free_vec;
    logic [REGION_SLOTS-1:0] free_oh;
    logic [REGION_SLOTS-1:0] sel_hold;
    logic [ADDR_BITS-1:0]    base_sel;
    logic [AX_W-1:0]         off_full;
    logic [SLOT_W-1:0]       wr_idx;
    logic                    map_we;
    logic                    unmap_we;
    logic                    prot_we;

    function automatic logic [SLOT_W-1:0] encode(input logic [REGION_SLOTS-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < REGION_SLOTS; i++)
        begin
            if (oh[i])
            begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // an address at or above twice the space size can never be in range
    assign addr_small = (req_reg.address[ADDR_W-1:AX_W] == '0);
    assign addr_x     = req_reg.address[AX_W-1:0];
    assign addr_s     = SUM_W'(addr_x);
    assign end_s      = addr_s + SUM_W'(req_reg.length);
    assign need_write = (req_reg.command == CMD_WRITE);

    always_comb
    begin
        logic [SUM_W-1:0] base_s;
        logic [SUM_W-1:0] rend_s;
        logic             perm_ok;
        logic             holds;
        bad_next = (req_reg.length == '0) || !addr_small || (end_s > SPACE_SIZE);
        for (int i = 0; i < REGION_SLOTS; i++)
        begin
            base_s  = SUM_W'(base_reg[i]);
            rend_s  = base_s + SUM_W'(len_reg[i]);
            perm_ok = need_write ? perm_reg[i][PERM_WRITE_BIT] : perm_reg[i][PERM_READ_BIT];
            holds   = valid_reg[i] && perm_ok && addr_small
                      && (addr_s >= base_s) && (end_s <= rend_s);
            overlap_next[i] = valid_reg[i] && (addr_s < rend_s) && (base_s < end_s);
            exact_next[i]   = valid_reg[i] && addr_small && (addr_s == base_s)
                              && (len_reg[i] == req_reg.length);
            // only a zero-length access on a shared boundary hits two regions
            hold_lo_next[i] = holds && (addr_s != base_s);
            hold_eq_next[i] = holds && (addr_s == base_s);
        end
    end

    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (valid_reg + REGION_SLOTS'(1));
    assign sel_hold = (|hold_lo_reg) ? hold_lo_reg : hold_eq_reg;

    always_comb
    begin
        base_sel = '0;
        for (int i = 0; i < REGION_SLOTS; i++)
        begin
            if (sel_hold[i])
            begin
                base_sel = base_sel | base_reg[i];
            end
        end
    end

    assign off_full = addr_x - AX_W'(base_sel);

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ST_NO_MATCH;
        wr_idx          = '0;
        map_we          = 1'b0;
        unmap_we        = 1'b0;
        prot_we         = 1'b0;
        unique case (req_reg.command) inside
            CMD_MAP:
            begin
                if (bad_reg)
                begin
                    rsp_next.status = ST_BAD_RANGE;
                end
                else if (|overlap_reg)
                begin
                    rsp_next.status = ST_OVERLAP;
                end
                else if (free_vec == '0)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    wr_idx              = encode(free_oh);
                    map_we              = 1'b1;
                    rsp_next.status     = ST_OK;
                    rsp_next.slot_index = SLOT_IDX_W'(wr_idx);
                end
            end
            CMD_UNMAP, CMD_PROTECT:
            begin
                if (|exact_reg)
                begin
                    wr_idx              = encode(exact_reg);
                    unmap_we            = (req_reg.command == CMD_UNMAP);
                    prot_we             = (req_reg.command == CMD_PROTECT);
                    rsp_next.status     = ST_OK;
                    rsp_next.slot_index = SLOT_IDX_W'(wr_idx);
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                if (|sel_hold)
                begin
                    rsp_next.status        = ST_OK;
                    rsp_next.slot_index    = SLOT_IDX_W'(encode(sel_hold));
                    rsp_next.region_offset = OFFSET_W'(off_full);
                end
            end
            default:
            begin
                rsp_next.status = ST_NO_MATCH;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.commit && map_we)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        else if (ctl.commit && unmap_we)
        begin
            valid_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req_data;
        end
        if (ctl.compare)
        begin
            bad_reg     <= bad_next;
            overlap_reg <= overlap_next;
            exact_reg   <= exact_next;
            hold_lo_reg <= hold_lo_next;
            hold_eq_reg <= hold_eq_next;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (ctl.commit && map_we)
        begin
            base_reg[wr_idx] <= req_reg.address[ADDR_BITS-1:0];
            len_reg[wr_idx]  <= req_reg.length;
        end
        if (ctl.commit && (map_we || prot_we))
        begin
            perm_reg[wr_idx] <= req_reg.permissions;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

### design/region_map_protection_checker_top.sv
// The result is registered once the request is captured, all slots are compared at once
//   and the resolve step commits; resolve waits while the result register is stalled.
// No new request is taken until the resolve step of the last one commits.
// A new request is taken while a finished result still waits on the output.
// Reset clears the sequencer, the output valid and every slot's valid bit at once.
// Top level of the region map protection checker.
module region_map_protection_checker_top
    import rmpc_pkg::*;
#(
    parameter int REGION_SLOTS = 16,
    parameter int ADDR_BITS    = 34
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    ctl_cmd_t ctl;

    rmpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    rmpc_datapath #(
        .REGION_SLOTS (REGION_SLOTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

### design/rmpc_checker.sv
// Port-level checker for the region map protection checker, with its bind.
`include "region_map_protection_checker_top_macros.svh"

module rmpc_checker
    import rmpc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    // the block stays busy through compare and resolve
    `RMPC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    `RMPC_ASSERT_NEXT(a_busy_two_cycles, req_valid && !req_stall, ##1 req_stall)
    `RMPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
    // a failed transaction reports no slot and no offset
    `RMPC_ASSERT_SAME(a_fail_clean, rsp_valid && (rsp_data.status != ST_OK),
        (rsp_data.slot_index == '0) && (rsp_data.region_offset == '0))

endmodule

bind region_map_protection_checker_top rmpc_checker u_rmpc_checker (.*);
